>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever a holds, b holds too.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever a holds, b holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types, sizes and codes shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    // Operation codes carried in the func field.
    localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FN_POP_FRONT  = 3'd2;
    localparam logic [2:0] FN_POP_BACK   = 3'd3;
    localparam logic [2:0] FN_LIST       = 3'd4;

    // Result status codes.
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push_front;
        logic       push_back;
        logic       pop_front;
        logic       pop_back;
        logic       list_start;
        logic       list_read;
        logic       list_next;
        logic       out_load;
        logic       out_from_mem;
        logic [1:0] out_status;
        logic       out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
    } t_dp_status;

endpackage

>>> rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit - bounded deque of signed 32-bit values in a ring
// Push and pop: result registered at accept; one item per cycle unless the output stalls.
// List: each value is read, then loaded; the input stalls until the last one is loaded.
// Reset empties the queue at once (front and fill zero); no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  deq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output deq_pkg::t_out_item o_out_item
);
    import deq_pkg::*;

    // The controller decides what happens to each accepted item and walks
    // the ring during a list. The datapath holds the ring storage, the
    // front index, the fill count and the result register.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The result register decouples the two channels: a new item is taken
    // in the same cycle as the previous result is drained.
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in_item.func),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // Pushes write the ring on the accepting edge; list reads are registered
    // in r_rd_data before the value can be placed in the result.
    deq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_item_value (i_in_item.item_value),
        .o_status     (dp_status),
        .o_out_item   (o_out_item)
    );

    // A push is never carried out on a full queue, nor a pop on an empty one.
    `ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, dp_cmd.push_front || dp_cmd.push_back, !dp_status.full)
    `ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, dp_cmd.pop_front || dp_cmd.pop_back, !dp_status.empty)
    // A result is only loaded while the result register is free or draining.
    `ASSERT_IMPLIES(a_load_free, i_clk, i_rst_n, dp_cmd.out_load, !(o_out_valid && i_out_stall))
    // Every loaded result is presented in the following cycle.
    `ASSERT_NEXT(a_load_shown, i_clk, i_rst_n, dp_cmd.out_load, o_out_valid)

endmodule

>>> rtl/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Ring storage, front index, fill count, list cursor and result register.
// ----------------------------------------------------------------------------
module deq_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  deq_pkg::t_dp_cmd    i_cmd,
    input  logic signed [31:0]  i_item_value,
    output deq_pkg::t_dp_status o_status,
    output deq_pkg::t_out_item  o_out_item
);
    import deq_pkg::*;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic [IDX_W-1:0]   r_front, n_front;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx;
    t_out_item          r_out_item;

    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   wr_addr;
    logic [CNT_W-1:0]   idx_plus1;

    // Ring position pos + off, both below DEPTH, so one subtract corrects it.
    function automatic logic [IDX_W-1:0] ring_add(logic [IDX_W-1:0] pos,
                                                  logic [IDX_W-1:0] off);
        logic [IDX_W:0] s;
        s = {1'b0, pos} + {1'b0, off};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[IDX_W-1:0];
    endfunction

    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - IDX_W'(1);
    assign wr_addr   = i_cmd.push_front ? front_dec
                                        : ring_add(r_front, r_count[IDX_W-1:0]);
    assign idx_plus1 = CNT_W'(r_idx) + CNT_W'(1);

    assign o_status.empty     = (r_count == '0);
    assign o_status.full      = (r_count == DEPTH_C);
    assign o_status.list_last = (idx_plus1 == r_count);
    assign o_out_item         = r_out_item;

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        if (i_cmd.push_front) begin
            n_front = front_dec;
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.push_back) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop_front || i_cmd.pop_back) begin
            n_count = r_count - CNT_W'(1);
            if (i_cmd.pop_front) begin
                n_front = ring_add(r_front, IDX_W'(1));
            end
            // An emptied queue restarts at ring position zero.
            if (n_count == '0) begin
                n_front = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (i_cmd.list_start) begin
                r_idx <= '0;
            end else if (i_cmd.list_next) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_front || i_cmd.push_back) begin
            r_mem[wr_addr] <= i_item_value;
        end
        if (i_cmd.list_read) begin
            r_rd_data <= r_mem[ring_add(r_front, r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.out_value <= i_cmd.out_from_mem ? r_rd_data : 32'sd0;
            r_out_item.status    <= i_cmd.out_status;
            r_out_item.last      <= i_cmd.out_last;
        end
    end

endmodule

>>> rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for operations and list walks, and owner of the result valid.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [2:0]          i_func,
    input  logic                i_out_stall,
    input  deq_pkg::t_dp_status i_status,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output deq_pkg::t_dp_cmd    o_cmd
);
    import deq_pkg::*;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_LIST_RD  = 2'd1;
    localparam logic [1:0] ST_LIST_OUT = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       in_fire;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || !out_free;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    o_cmd.out_last = 1'b1;
                    unique case (i_func)
                        FN_PUSH_FRONT, FN_PUSH_BACK: begin
                            o_cmd.out_load = 1'b1;
                            if (i_status.full) begin
                                o_cmd.out_status = STS_FULL;
                            end else begin
                                o_cmd.out_status = STS_OK;
                                o_cmd.push_front = (i_func == FN_PUSH_FRONT);
                                o_cmd.push_back  = (i_func == FN_PUSH_BACK);
                            end
                        end
                        FN_POP_FRONT, FN_POP_BACK: begin
                            o_cmd.out_load = 1'b1;
                            if (i_status.empty) begin
                                o_cmd.out_status = STS_EMPTY;
                            end else begin
                                o_cmd.out_status = STS_OK;
                                o_cmd.pop_front  = (i_func == FN_POP_FRONT);
                                o_cmd.pop_back   = (i_func == FN_POP_BACK);
                            end
                        end
                        FN_LIST: begin
                            if (i_status.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = STS_EMPTY;
                            end else begin
                                o_cmd.list_start = 1'b1;
                                n_state          = ST_LIST_RD;
                            end
                        end
                        default: begin
                            // Unused codes are consumed without a result.
                        end
                    endcase
                end
            end
            ST_LIST_RD: begin
                o_cmd.list_read = 1'b1;
                n_state         = ST_LIST_OUT;
            end
            ST_LIST_OUT: begin
                if (out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_from_mem = 1'b1;
                    o_cmd.out_status   = STS_OK;
                    o_cmd.out_last     = i_status.list_last;
                    if (i_status.list_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.list_next = 1'b1;
                        n_state         = ST_LIST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> verif/double_ended_queue_checker.sv
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches both channels of the deque unit. It keeps its own copy of the ring
// and predicts the results of every accepted item. It compares the results
// in order and counts the failures for the testbench top.
// ----------------------------------------------------------------------------
module double_ended_queue_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  deq_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  deq_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending
);
    import deq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic signed [31:0] ring_values [DEPTH];
    logic [IDX_W-1:0]   front_index;
    logic [CNT_W-1:0]   fill_count;
    t_out_item          awaited_results [$];
    int                 failures;

    function automatic logic [IDX_W-1:0] ring_pos(input int offset);
        return IDX_W'((int'(front_index) + offset) % DEPTH);
    endfunction

    task automatic await_result(input logic signed [31:0] value, input logic [1:0] status,
                                input logic last);
        t_out_item res;
        res.out_value = value;
        res.status    = status;
        res.last      = last;
        awaited_results.push_back(res);
    endtask

    // Applies one operation to the shadow deque and queues what it answers.
    task automatic apply_deque_op(input t_in_item item);
        int k;
        case (item.func)
            FN_PUSH_FRONT: begin
                if (fill_count == DEPTH_C) begin
                    await_result('0, STS_FULL, 1'b1);
                end else begin
                    front_index = (front_index == '0) ? LAST_IDX : front_index - 1'b1;
                    ring_values[front_index] = item.item_value;
                    fill_count = fill_count + 1'b1;
                    await_result('0, STS_OK, 1'b1);
                end
            end
            FN_PUSH_BACK: begin
                if (fill_count == DEPTH_C) begin
                    await_result('0, STS_FULL, 1'b1);
                end else begin
                    ring_values[ring_pos(int'(fill_count))] = item.item_value;
                    fill_count = fill_count + 1'b1;
                    await_result('0, STS_OK, 1'b1);
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (fill_count == '0) begin
                    await_result('0, STS_EMPTY, 1'b1);
                end else begin
                    if (item.func == FN_POP_FRONT) begin
                        front_index = ring_pos(1);
                    end
                    fill_count = fill_count - 1'b1;
                    // An emptied deque starts over at position zero.
                    if (fill_count == '0) begin
                        front_index = '0;
                    end
                    await_result('0, STS_OK, 1'b1);
                end
            end
            FN_LIST: begin
                if (fill_count == '0) begin
                    await_result('0, STS_EMPTY, 1'b1);
                end else begin
                    for (k = 0; k < int'(fill_count); k++) begin
                        await_result(ring_values[ring_pos(k)], STS_OK,
                                     k == int'(fill_count) - 1);
                    end
                end
            end
            default: begin
                // The spare function codes leave the deque alone and answer nothing.
            end
        endcase
    endtask

    task automatic log_failure(input string what, input t_out_item want, input t_out_item got);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("deque check: %s: expected value %0d status %0d last %0d, got value %0d status %0d last %0d",
                     what, want.out_value, want.status, want.last,
                     got.out_value, got.status, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            front_index = '0;
            fill_count  = '0;
            failures    = 0;
            awaited_results.delete();
        end else begin
            // Results are compared before new items are predicted, since no item
            // can be answered at the edge where it is accepted.
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    log_failure("result with none due", '0, i_out_item);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_item.out_value !== want.out_value
                            || i_out_item.status !== want.status
                            || i_out_item.last !== want.last) begin
                        log_failure("mismatch", want, i_out_item);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_deque_op(i_in_item);
            end
        end
        o_fail_count <= failures;
        o_pending    <= awaited_results.size();
    end

endmodule

>>> verif/double_ended_queue_unit_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit_test
// Drives the deque unit with a short directed sequence and then random items
// under three idling patterns. A long output hold-off makes the unit stall
// its input. The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_test;
    import deq_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    // Random items to send after the directed part. Ignored codes do not count.
    localparam int RANDOM_ITEMS = 210;
    // The receiver holds off this long while the sender keeps pushing.
    localparam int HOLD_CYCLES  = 200;
    // A full list reads and then loads each entry in turn, so this covers the
    // longest answer to an item with room to spare.
    localparam int DRAIN_CYCLES = 4 * DEPTH;
    // The slowest run lists a full deque on every item: about 300 items, 16
    // results each, every result read and then loaded, and slowed further by
    // the stalls. This limit leaves ample room for that.
    localparam int CYCLE_LIMIT  = 400_000;

    // Function codes that the unit ignores.
    localparam logic [2:0] FN_SPARE_5 = 3'd5;
    localparam logic [2:0] FN_SPARE_6 = 3'd6;
    localparam logic [2:0] FN_SPARE_7 = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    int        fail_count;
    int        pending;

    // Idle and stall rates in percent. The stimulus process sets them per phase.
    int send_idle_pct  = 0;
    int take_stall_pct = 0;
    int items_sent     = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    int cycle_count    = 0;
    int random_base    = 0;

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    double_ended_queue_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    double_ended_queue_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Values lean toward the extremes now and then, so that the sign bit and
    // the all-ones and all-zeros patterns travel through the ring often.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(15))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_spare_func();
        case ($urandom_range(2))
            0: return FN_SPARE_5;
            1: return FN_SPARE_6;
            default: return FN_SPARE_7;
        endcase
    endfunction

    // Offers one item and returns at the edge where the unit accepts it. An
    // optional idle gap comes first. Valid stays high from one item to the
    // next when no gap is drawn, so each step sees one assignment at most.
    task automatic send_item(input logic [2:0] func, input logic signed [31:0] value);
        t_in_item item;
        item.func       = func;
        item.item_value = value;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do begin
                @(posedge clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (func <= FN_LIST) begin
            items_sent++;
        end
    endtask

    // One operation drawn with pushes ahead of pops, so the fill level
    // wanders over the whole range and the ring wraps both ways.
    task automatic send_mixed_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) begin
            send_item(FN_PUSH_FRONT, pick_value());
        end else if (roll < 50) begin
            send_item(FN_PUSH_BACK, pick_value());
        end else if (roll < 65) begin
            send_item(FN_POP_FRONT, pick_value());
        end else if (roll < 80) begin
            send_item(FN_POP_BACK, pick_value());
        end else if (roll < 92) begin
            send_item(FN_LIST, pick_value());
        end else begin
            send_item(pick_spare_func(), pick_value());
        end
    endtask

    // Pushes past full from any starting level, lists the full deque, then pops
    // past empty and lists the empty deque.
    task automatic fill_and_drain();
        repeat (DEPTH + 2) begin
            send_item($urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT, pick_value());
        end
        send_item(FN_LIST, pick_value());
        repeat (DEPTH + 2) begin
            send_item($urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT, pick_value());
        end
        send_item(FN_LIST, pick_value());
    endtask

    // Drops valid and waits until every predicted result is back. The pending
    // count is registered in the checker, hence the first wait. The extra
    // cycles let the unit finish anything that answers nothing.
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) begin
            @(posedge clk);
        end
    endtask

    // Receiver. It stalls at random at the current rate. When a hold-off is
    // requested, it stalls for a fixed count of cycles while the sender goes on.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_requests != holds_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge clk);
                end
                holds_done++;
            end
            out_stall <= ($urandom_range(99) < take_stall_pct);
        end
    end

    // Watchdog over the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("double_ended_queue_unit_test: done, errors");
        $finish;
    end

    initial begin
        int phase;
        repeat (RESET_CYCLES) begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 36;
        take_stall_pct = 51;

        // Directed part. First the empty cases, then the value extremes through
        // both ends. A pop back of a one-entry deque must empty it. The spare
        // codes must be ignored.
        send_item(FN_LIST, '0);
        send_item(FN_POP_FRONT, '0);
        send_item(FN_POP_BACK, VAL_MAX);
        send_item(FN_PUSH_FRONT, VAL_MIN);
        send_item(FN_PUSH_BACK, VAL_MAX);
        send_item(FN_PUSH_FRONT, -32'sd1);
        send_item(FN_PUSH_BACK, '0);
        send_item(FN_LIST, VAL_MIN);
        send_item(FN_POP_BACK, '0);
        send_item(FN_POP_FRONT, '0);
        send_item(FN_LIST, '0);
        send_item(FN_POP_FRONT, '0);
        send_item(FN_POP_BACK, '0);
        send_item(FN_LIST, '0);
        send_item(FN_PUSH_BACK, 32'sh5A5A_A5A5);
        send_item(FN_POP_BACK, '0);
        send_item(FN_LIST, -32'sd1);
        send_item(FN_SPARE_5, VAL_MAX);
        send_item(FN_SPARE_6, VAL_MIN);
        send_item(FN_SPARE_7, -32'sd1);
        send_item(FN_PUSH_FRONT, 32'sh0000_0001);
        send_item(FN_LIST, '0);
        send_item(FN_POP_FRONT, '0);
        send_item(FN_POP_FRONT, '0);
        // The sender waits here for every result before the random part.
        wait_for_quiet();

        random_base = items_sent;
        // The push-past-full case comes first of all.
        fill_and_drain();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 36;
                    take_stall_pct = 51;
                end
                1: begin
                    send_idle_pct  = 51;
                    take_stall_pct = 36;
                end
                default: begin
                    send_idle_pct  = 0;
                    take_stall_pct = 0;
                    // The receiver holds off while pushes and lists keep coming.
                    // The unit backs up and must stall its input without losing
                    // anything.
                    hold_requests <= hold_requests + 1;
                    repeat (DEPTH) begin
                        send_item(FN_PUSH_BACK, pick_value());
                    end
                    send_item(FN_LIST, pick_value());
                    send_item(FN_LIST, pick_value());
                    repeat (DEPTH / 2) begin
                        send_item(FN_POP_FRONT, pick_value());
                    end
                end
            endcase
            while (items_sent - random_base < (phase + 1) * RANDOM_ITEMS / 3) begin
                if ($urandom_range(99) < 15) begin
                    fill_and_drain();
                end else begin
                    repeat (8) begin
                        send_mixed_op();
                    end
                end
            end
            wait_for_quiet();
        end

        // Read the verdict away from the edge, after the checker's last update.
        @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("double_ended_queue_unit_test: done, clean");
        end else begin
            $display("double_ended_queue_unit_test: done, errors");
        end
        $finish;
    end

endmodule
